// ===== hdl/psaw_pkg.sv =====
// ----------------------------------------------------------------------------
// psaw_pkg
// Shared widths, codes and types for the PolyBLEP sawtooth oscillator.
// ----------------------------------------------------------------------------
package psaw_pkg;

  // Phase and sample formats
  localparam int PHASE_BITS  = 24;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;

  // Register widths
  localparam int INC_W   = 24;
  localparam int RECIP_W = 32;
  localparam int CFG_W   = 32;

  // Distance times reciprocal is scaled by 2^40; keep FRAC_BITS of fraction
  localparam int RECIP_SHIFT = 40 - FRAC_BITS;
  localparam int PROD_W      = PHASE_BITS + RECIP_W;
  localparam int XQ_W        = PROD_W - RECIP_SHIFT;
  localparam int SQ_W        = 2 * SAMPLE_BITS;

  // Register reset values
  localparam logic [INC_W-1:0]   INC_RESET   = INC_W'(65536);
  localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(16777216);

  // Register indexes
  localparam logic REG_PHASE_INC = 1'b0;
  localparam logic REG_INC_RECIP = 1'b1;

  // Input commands
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // Which side of the wrap the residual applies to
  typedef enum logic [1:0] {
    BLEP_NONE = 2'd0,
    BLEP_ADD  = 2'd1,
    BLEP_SUB  = 2'd2
  } blep_mode_t;

  // One classified tick, handed from front to back
  typedef struct packed {
    blep_mode_t                    mode;
    logic signed [SAMPLE_BITS-1:0] saw;
    logic [PHASE_BITS-1:0]         wrap_dist;
  } tick_rec_t;

endpackage

// ===== hdl/psaw_front.sv =====
// ----------------------------------------------------------------------------
// psaw_front
// Owns the phase accumulator: takes input beats, forms the naive saw and the
// distance to the wrap just passed, else to the one just ahead, and passes each tick on as a record.
// ----------------------------------------------------------------------------
module psaw_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic                               in_command,
  input  logic [psaw_pkg::PHASE_BITS-1:0]    in_phase_value,
  input  logic [psaw_pkg::INC_W-1:0]         phase_inc,
  output logic                               rec_push,
  output psaw_pkg::tick_rec_t                rec_data,
  input  logic                               rec_full
);
  import psaw_pkg::*;

  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [PHASE_BITS-1:0] inc;
  logic [PHASE_BITS:0]   dist_before;
  logic                  accept;
  logic                  win_after;
  logic                  win_before;

  assign inc     = PHASE_BITS'(phase_inc);
  assign in_full = rec_full;
  assign accept  = in_push & ~rec_full;

  // Window tests around the wrap
  assign dist_before = {1'b1, {PHASE_BITS{1'b0}}} - {1'b0, phase_r};
  assign win_after   = phase_r < inc;
  assign win_before  = dist_before < {1'b0, inc};

  // Classify the tick
  always_comb begin
    rec_data.saw = {~phase_r[PHASE_BITS-1], phase_r[PHASE_BITS-2 -: FRAC_BITS]};
    if (win_after) begin
      rec_data.mode      = BLEP_ADD;
      rec_data.wrap_dist = phase_r;
    end else if (win_before) begin
      rec_data.mode      = BLEP_SUB;
      rec_data.wrap_dist = dist_before[PHASE_BITS-1:0];
    end else begin
      rec_data.mode      = BLEP_NONE;
      rec_data.wrap_dist = phase_r;
    end
  end

  assign rec_push = accept & (in_command == CMD_TICK);

  // Phase update: load or advance
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      case (in_command)
        CMD_LOAD: phase_nxt = in_phase_value;
        default:  phase_nxt = phase_r + inc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

// ===== hdl/psaw_queue.sv =====
// ----------------------------------------------------------------------------
// psaw_queue
// Two-entry queue of tick records between the front and the back.
// ----------------------------------------------------------------------------
module psaw_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  psaw_pkg::tick_rec_t push_data,
  output logic                full,
  input  logic                pop,
  output psaw_pkg::tick_rec_t pop_data,
  output logic                empty
);
  import psaw_pkg::*;

  tick_rec_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push;
  logic       do_pop;

  assign full     = count_r == 2'd2;
  assign empty    = count_r == 2'd0;
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_data = mem_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/psaw_back.sv =====
// ----------------------------------------------------------------------------
// psaw_back
// Works out the PolyBLEP residual for each tick record: multiply by the
// reciprocal, clamp, square, apply and saturate, then hold results in an
// output queue. Issue is credit based so the pipeline never stalls.
// ----------------------------------------------------------------------------
module psaw_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [psaw_pkg::RECIP_W-1:0]        inc_recip,
  input  psaw_pkg::tick_rec_t                 rec_data,
  input  logic                                rec_empty,
  output logic                                rec_pop,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [psaw_pkg::SAMPLE_BITS-1:0] out_sample_value
);
  import psaw_pkg::*;

  localparam logic [XQ_W-1:0]        ONE_XQ = XQ_W'(1) << FRAC_BITS;
  localparam logic [SAMPLE_BITS-1:0] ONE_U  = SAMPLE_BITS'(1) << FRAC_BITS;
  localparam logic signed [SAMPLE_BITS+1:0] SAT_HI = (SAMPLE_BITS+2)'(ONE_U) - 1'sd1;
  localparam logic signed [SAMPLE_BITS+1:0] SAT_LO = -(SAMPLE_BITS+2)'(ONE_U);

  // Stage 1: product of distance and reciprocal
  logic                          v1_r;
  blep_mode_t                    mode1_r;
  logic signed [SAMPLE_BITS-1:0] saw1_r;
  logic [PROD_W-1:0]             prod1_r;

  // Stage 2: square of one minus the normalised distance
  logic                          v2_r;
  blep_mode_t                    mode2_r;
  logic signed [SAMPLE_BITS-1:0] saw2_r;
  logic [SQ_W-1:0]               sq2_r;

  // Output queue
  logic signed [SAMPLE_BITS-1:0] oq_r [4];
  logic [1:0]                    oq_wr_r;
  logic [1:0]                    oq_rd_r;
  logic [2:0]                    oq_cnt_r, oq_cnt_nxt;

  logic [XQ_W-1:0]               xq;
  logic [SAMPLE_BITS-1:0]        u1;
  logic [SAMPLE_BITS-1:0]        mag;
  logic signed [SAMPLE_BITS+1:0] sum;
  logic signed [SAMPLE_BITS-1:0] res;
  logic [2:0]                    in_flight;
  logic                          do_pop_out;

  // Issue only when the output queue has room for everything in flight
  assign in_flight  = oq_cnt_r + 3'(v1_r) + 3'(v2_r);
  assign rec_pop    = ~rec_empty & (in_flight < 3'd4);
  assign out_empty  = oq_cnt_r == 3'd0;
  assign do_pop_out = out_pop & ~out_empty;
  assign out_sample_value = oq_r[oq_rd_r];

  // Normalised distance, clamped to one
  always_comb begin
    xq = prod1_r[PROD_W-1:RECIP_SHIFT];
    if (xq > ONE_XQ) begin
      u1 = '0;
    end else begin
      u1 = ONE_U - xq[SAMPLE_BITS-1:0];
    end
  end

  // Apply residual and saturate
  always_comb begin
    mag = sq2_r[FRAC_BITS +: SAMPLE_BITS];
    case (mode2_r)
      BLEP_ADD: sum = (SAMPLE_BITS+2)'(saw2_r) + $signed({2'b00, mag});
      BLEP_SUB: sum = (SAMPLE_BITS+2)'(saw2_r) - $signed({2'b00, mag});
      default:  sum = (SAMPLE_BITS+2)'(saw2_r);
    endcase
    if (sum > SAT_HI) begin
      res = SAT_HI[SAMPLE_BITS-1:0];
    end else if (sum < SAT_LO) begin
      res = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      res = sum[SAMPLE_BITS-1:0];
    end
  end

  assign oq_cnt_nxt = oq_cnt_r + 3'(v2_r) - 3'(do_pop_out);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      oq_wr_r  <= 2'd0;
      oq_rd_r  <= 2'd0;
      oq_cnt_r <= 3'd0;
    end else begin
      v1_r     <= rec_pop;
      v2_r     <= v1_r;
      oq_cnt_r <= oq_cnt_nxt;
      if (v2_r) begin
        oq_wr_r <= oq_wr_r + 2'd1;
      end
      if (do_pop_out) begin
        oq_rd_r <= oq_rd_r + 2'd1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mode1_r <= rec_data.mode;
    saw1_r  <= rec_data.saw;
    prod1_r <= PROD_W'(rec_data.wrap_dist) * PROD_W'(inc_recip);
    mode2_r <= mode1_r;
    saw2_r  <= saw1_r;
    sq2_r   <= SQ_W'(u1) * SQ_W'(u1);
    if (v2_r) begin
      oq_r[oq_wr_r] <= res;
    end
  end

endmodule

// ===== hdl/polyblep_sawtooth_oscillator.sv =====
// ----------------------------------------------------------------------------
// polyblep_sawtooth_oscillator
// Band-limited sawtooth oscillator with a PolyBLEP correction at the wrap.
// ----------------------------------------------------------------------------
// Takes one input beat a clock while in_full is low: a tick yields one Q1.15
// saturated sample, a load sets the phase and yields nothing. The front
// updates the phase in the cycle of acceptance and queues the tick; the back
// takes it when the output queue has room, runs a two-stage pipeline
// (reciprocal multiply, then the square), applies the residual and writes the
// sample out. Up to two ticks wait between front and back and up to four
// samples at the output; a stall holds the other side only once they fill.
// ----------------------------------------------------------------------------
module polyblep_sawtooth_oscillator (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_push,
  output logic                                    in_full,
  input  logic                                    in_command,
  input  logic [psaw_pkg::PHASE_BITS-1:0]         in_phase_value,
  output logic                                    out_empty,
  input  logic                                    out_pop,
  output logic signed [psaw_pkg::SAMPLE_BITS-1:0] out_sample_value,
  input  logic                                    cfg_we,
  input  logic                                    cfg_index,
  input  logic [psaw_pkg::CFG_W-1:0]              cfg_data
);
  import psaw_pkg::*;

  logic [INC_W-1:0]   inc_r;
  logic [RECIP_W-1:0] recip_r;
  tick_rec_t          push_rec;
  tick_rec_t          pop_rec;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r   <= INC_RESET;
      recip_r <= RECIP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE_INC: inc_r   <= cfg_data[INC_W-1:0];
        REG_INC_RECIP: recip_r <= cfg_data[RECIP_W-1:0];
        default:       ;
      endcase
    end
  end

  psaw_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_command     (in_command),
    .in_phase_value (in_phase_value),
    .phase_inc      (inc_r),
    .rec_push       (q_push),
    .rec_data       (push_rec),
    .rec_full       (q_full)
  );

  psaw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_rec),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_rec),
    .empty     (q_empty)
  );

  psaw_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .inc_recip        (recip_r),
    .rec_data         (pop_rec),
    .rec_empty        (q_empty),
    .rec_pop          (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_sample_value (out_sample_value)
  );

endmodule
